/* rtl/lbs_pkg.sv */
`default_nettype none
package lbs_pkg;

    localparam int SHADE_LEVELS  = 64;
    localparam int TABLE_COLS    = 256;
    localparam int TABLE_ENTRIES = SHADE_LEVELS * TABLE_COLS;
    localparam int ROW_W         = $clog2(SHADE_LEVELS);
    localparam int COL_W         = $clog2(TABLE_COLS);
    localparam int ADDR_W        = ROW_W + COL_W;

    localparam int BLOCK_EDGE    = 16;
    localparam int EDGE_SHIFT    = $clog2(BLOCK_EDGE);
    localparam int POS_W         = EDGE_SHIFT;
    localparam int LIGHT_SHIFT   = 16;
    localparam int LEVEL_SHIFT   = 18;
    localparam int LEVEL_W       = LEVEL_SHIFT + ROW_W;
    // a block started at the smallest edge can walk sixteen rows at half-edge steps
    // once the mip level grows, so edges and spans carry five extra bits
    localparam int SPAN_W        = LEVEL_W + EDGE_SHIFT + 1;

    localparam logic [7:0] LIGHT_MAX = 8'hff;

    localparam int CMDQ_DEPTH    = 4;
    localparam int RESQ_DEPTH    = 4;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_TEXEL = 2'd2;

    typedef logic signed [SPAN_W-1:0] t_span;
    typedef logic [LEVEL_W-1:0]       t_level;

    typedef enum logic [1:0] {
        CMD_WRITE,
        CMD_START,
        CMD_TEXEL
    } t_cmd_kind;

    typedef struct packed {
        logic [1:0]       operation;
        logic [7:0]       light_top_left;
        logic [7:0]       light_top_right;
        logic [7:0]       light_bottom_left;
        logic [7:0]       light_bottom_right;
        logic [COL_W-1:0] texel;
        logic [ROW_W-1:0] shade_row;
        logic [7:0]       shade_value;
    } t_in_item;

    typedef struct packed {
        logic [7:0]       pixel;
        logic [POS_W-1:0] column;
        logic [POS_W-1:0] row;
        logic             last_of_block;
    } t_result;

    typedef struct packed {
        t_cmd_kind        kind;
        logic [7:0]       inv_top_left;
        logic [7:0]       inv_top_right;
        logic [7:0]       inv_bottom_left;
        logic [7:0]       inv_bottom_right;
        logic [COL_W-1:0] texel;
        logic [ROW_W-1:0] shade_row;
        logic [7:0]       shade_value;
    } t_cmd;

    typedef struct packed {
        logic [POS_W-1:0] column;
        logic [POS_W-1:0] row;
        logic             last_of_block;
    } t_pix_meta;

endpackage
`default_nettype wire

/* rtl/lbs_front.sv */
`default_nettype none
module lbs_front (
    input  var lbs_pkg::t_in_item i_item,
    input  var logic              i_push,
    output logic                  o_full,
    output logic                  o_cmd_push,
    output lbs_pkg::t_cmd         o_cmd,
    input  var logic              i_cmd_full
);

    logic accept;

    assign o_full = i_cmd_full;
    assign accept = i_push && !i_cmd_full;

    always_comb begin
        o_cmd.inv_top_left     = lbs_pkg::LIGHT_MAX - i_item.light_top_left;
        o_cmd.inv_top_right    = lbs_pkg::LIGHT_MAX - i_item.light_top_right;
        o_cmd.inv_bottom_left  = lbs_pkg::LIGHT_MAX - i_item.light_bottom_left;
        o_cmd.inv_bottom_right = lbs_pkg::LIGHT_MAX - i_item.light_bottom_right;
        o_cmd.texel            = i_item.texel;
        o_cmd.shade_row        = i_item.shade_row;
        o_cmd.shade_value      = i_item.shade_value;
        o_cmd.kind             = lbs_pkg::CMD_TEXEL;
        o_cmd_push             = 1'b0;
        unique case (i_item.operation)
            lbs_pkg::OP_WRITE: begin
                o_cmd.kind = lbs_pkg::CMD_WRITE;
                o_cmd_push = accept;
            end
            lbs_pkg::OP_START: begin
                o_cmd.kind = lbs_pkg::CMD_START;
                o_cmd_push = accept;
            end
            lbs_pkg::OP_TEXEL: begin
                o_cmd.kind = lbs_pkg::CMD_TEXEL;
                o_cmd_push = accept;
            end
            default: begin
                // unused code, item taken and dropped
                o_cmd_push = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

/* rtl/lbs_cmd_queue.sv */
`default_nettype none
module lbs_cmd_queue (
    input  var logic          i_clk,
    input  var logic          i_rst_n,
    input  var logic          i_push,
    input  var lbs_pkg::t_cmd i_cmd,
    output logic              o_full,
    input  var logic          i_pop,
    output logic              o_empty,
    output lbs_pkg::t_cmd     o_head
);

    localparam int PTR_W = $clog2(lbs_pkg::CMDQ_DEPTH);
    localparam int CNT_W = $clog2(lbs_pkg::CMDQ_DEPTH + 1);

    lbs_pkg::t_cmd    r_entry [lbs_pkg::CMDQ_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(lbs_pkg::CMDQ_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_entry[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + PTR_W'(1) : r_wr_ptr;
        n_rd_ptr = do_pop  ? r_rd_ptr + PTR_W'(1) : r_rd_ptr;
        n_count  = r_count + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wr_ptr] <= i_cmd;
        end
    end

endmodule
`default_nettype wire

/* rtl/lbs_back.sv */
`default_nettype none
module lbs_back (
    input  var logic             i_clk,
    input  var logic             i_rst_n,
    input  var logic             i_cfg_wr_en,
    input  var logic [1:0]       i_cfg_wr_data,
    input  var logic             i_cmd_empty,
    input  var lbs_pkg::t_cmd    i_cmd,
    output logic                 o_cmd_pop,
    output logic                 o_empty,
    input  var logic             i_pop,
    output lbs_pkg::t_result     o_result
);

    localparam int RPTR_W = $clog2(lbs_pkg::RESQ_DEPTH);
    localparam int RCNT_W = $clog2(lbs_pkg::RESQ_DEPTH + 1);
    localparam int SH_W   = $clog2(lbs_pkg::EDGE_SHIFT + 1);
    localparam int STEP_W = lbs_pkg::POS_W + 1;

    // block state
    logic [1:0]          r_mip_level;
    logic                r_active, n_active;
    lbs_pkg::t_span      r_left, n_left;
    lbs_pkg::t_span      r_left_step, n_left_step;
    lbs_pkg::t_span      r_span, n_span;
    lbs_pkg::t_span      r_span_step, n_span_step;
    lbs_pkg::t_level     r_pixel_level, n_pixel_level;
    lbs_pkg::t_level     r_pixel_step, n_pixel_step;
    logic [lbs_pkg::POS_W-1:0] r_col, n_col;
    logic [lbs_pkg::POS_W-1:0] r_row, n_row;

    // shade table and read stage
    logic [7:0]                  r_shade_table [lbs_pkg::TABLE_ENTRIES];
    logic                        tbl_we;
    logic                        tbl_re;
    logic [lbs_pkg::ADDR_W-1:0]  tbl_waddr;
    logic [lbs_pkg::ADDR_W-1:0]  tbl_raddr;
    logic [7:0]                  r_rd_data;
    logic                        r_rd_valid, n_rd_valid;
    lbs_pkg::t_pix_meta          r_rd_meta, n_rd_meta;

    // result queue
    lbs_pkg::t_result   r_res [lbs_pkg::RESQ_DEPTH];
    logic [RPTR_W-1:0]  r_res_wr_ptr;
    logic [RPTR_W-1:0]  r_res_rd_ptr;
    logic [RCNT_W-1:0]  r_res_count;
    logic               res_push;
    logic               res_pop;
    logic               room;

    logic [SH_W-1:0]    sh;
    logic [STEP_W-1:0]  step;
    logic [STEP_W-1:0]  col_inc;
    logic [STEP_W-1:0]  row_inc;
    lbs_pkg::t_span     c_tl, c_tr, c_bl, c_br;
    lbs_pkg::t_span     d_left, d_right, d_top;

    assign sh   = SH_W'(lbs_pkg::EDGE_SHIFT) - SH_W'(r_mip_level);
    assign step = STEP_W'(lbs_pkg::BLOCK_EDGE) >> r_mip_level;

    assign c_tl    = lbs_pkg::t_span'(i_cmd.inv_top_left) << lbs_pkg::LIGHT_SHIFT;
    assign c_tr    = lbs_pkg::t_span'(i_cmd.inv_top_right) << lbs_pkg::LIGHT_SHIFT;
    assign c_bl    = lbs_pkg::t_span'(i_cmd.inv_bottom_left) << lbs_pkg::LIGHT_SHIFT;
    assign c_br    = lbs_pkg::t_span'(i_cmd.inv_bottom_right) << lbs_pkg::LIGHT_SHIFT;
    assign d_left  = c_bl - c_tl;
    assign d_right = c_br - c_tr;
    assign d_top   = c_tr - c_tl;

    assign col_inc = STEP_W'(r_col) + STEP_W'(1);
    assign row_inc = STEP_W'(r_row) + STEP_W'(1);

    // a texel read needs a free slot counting the one in flight
    assign room = ({1'b0, r_res_count} + (RCNT_W + 1)'(r_rd_valid))
                  < (RCNT_W + 1)'(lbs_pkg::RESQ_DEPTH);

    assign o_cmd_pop = !i_cmd_empty
                       && (i_cmd.kind != lbs_pkg::CMD_TEXEL || !r_active || room);

    assign tbl_waddr = {i_cmd.shade_row, i_cmd.texel};
    assign tbl_raddr = {r_pixel_level[lbs_pkg::LEVEL_W-1 -: lbs_pkg::ROW_W], i_cmd.texel};

    always_comb begin
        n_active      = r_active;
        n_left        = r_left;
        n_left_step   = r_left_step;
        n_span        = r_span;
        n_span_step   = r_span_step;
        n_pixel_level = r_pixel_level;
        n_pixel_step  = r_pixel_step;
        n_col         = r_col;
        n_row         = r_row;
        n_rd_valid    = 1'b0;
        n_rd_meta     = r_rd_meta;
        tbl_we        = 1'b0;
        tbl_re        = 1'b0;
        if (o_cmd_pop) begin
            unique case (i_cmd.kind)
                lbs_pkg::CMD_WRITE: begin
                    tbl_we = 1'b1;
                end
                lbs_pkg::CMD_START: begin
                    n_left        = c_tl;
                    n_left_step   = d_left >>> sh;
                    n_span        = d_top;
                    n_span_step   = (d_right - d_left) >>> sh;
                    n_pixel_level = c_tl[lbs_pkg::LEVEL_W-1:0];
                    n_pixel_step  = lbs_pkg::LEVEL_W'(d_top >>> sh);
                    n_col         = '0;
                    n_row         = '0;
                    n_active      = 1'b1;
                end
                lbs_pkg::CMD_TEXEL: begin
                    if (r_active) begin
                        tbl_re                  = 1'b1;
                        n_rd_valid              = 1'b1;
                        n_rd_meta.column        = r_col;
                        n_rd_meta.row           = r_row;
                        n_rd_meta.last_of_block = 1'b0;
                        n_pixel_level           = r_pixel_level + r_pixel_step;
                        n_col                   = col_inc[lbs_pkg::POS_W-1:0];
                        if (col_inc >= step) begin
                            // end of row: walk both edges down
                            n_col         = '0;
                            n_left        = r_left + r_left_step;
                            n_span        = r_span + r_span_step;
                            n_pixel_level = n_left[lbs_pkg::LEVEL_W-1:0];
                            n_pixel_step  = lbs_pkg::LEVEL_W'(n_span >>> sh);
                            n_row         = row_inc[lbs_pkg::POS_W-1:0];
                            if (row_inc >= step) begin
                                n_row                   = '0;
                                n_active                = 1'b0;
                                n_rd_meta.last_of_block = 1'b1;
                            end
                        end
                    end
                end
                default: begin
                    tbl_we = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mip_level   <= '0;
            r_active      <= 1'b0;
            r_left        <= '0;
            r_left_step   <= '0;
            r_span        <= '0;
            r_span_step   <= '0;
            r_pixel_level <= '0;
            r_pixel_step  <= '0;
            r_col         <= '0;
            r_row         <= '0;
            r_rd_valid    <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_mip_level <= i_cfg_wr_data;
            end
            r_active      <= n_active;
            r_left        <= n_left;
            r_left_step   <= n_left_step;
            r_span        <= n_span;
            r_span_step   <= n_span_step;
            r_pixel_level <= n_pixel_level;
            r_pixel_step  <= n_pixel_step;
            r_col         <= n_col;
            r_row         <= n_row;
            r_rd_valid    <= n_rd_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_meta <= n_rd_meta;
    end

    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            r_shade_table[tbl_waddr] <= i_cmd.shade_value;
        end
        if (tbl_re) begin
            r_rd_data <= r_shade_table[tbl_raddr];
        end
    end

    // result queue
    assign res_push = r_rd_valid;
    assign o_empty  = (r_res_count == '0);
    assign res_pop  = i_pop && !o_empty;
    assign o_result = r_res[r_res_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_wr_ptr <= '0;
            r_res_rd_ptr <= '0;
            r_res_count  <= '0;
        end else begin
            if (res_push) begin
                r_res_wr_ptr <= r_res_wr_ptr + RPTR_W'(1);
            end
            if (res_pop) begin
                r_res_rd_ptr <= r_res_rd_ptr + RPTR_W'(1);
            end
            r_res_count <= r_res_count + RCNT_W'(res_push) - RCNT_W'(res_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_push) begin
            r_res[r_res_wr_ptr] <= {r_rd_data, r_rd_meta};
        end
    end

endmodule
`default_nettype wire

/* rtl/lightmap_block_shader.sv */
// channel   direction  handshake             payload
// input     in         push / full           i_item   (lbs_pkg::t_in_item)
// result    out        empty / pop           o_result (lbs_pkg::t_result)
// config    in         i_cfg_wr_en           i_cfg_wr_data (mip level)
//
// one item a cycle sustained while full stays low; a texel item taken at the input passes
// the command queue and the shade table read before its pixel enters the result queue
// synchronous active-low reset clears control and block state; the shade table is
// defined only once written
// full rises when the four-entry command queue fills; texel items wait there while
// the four-entry result queue has no free slot
`default_nettype none
module lightmap_block_shader (
    input  var logic              i_clk,
    input  var logic              i_rst_n,
    input  var logic              i_cfg_wr_en,
    input  var logic [1:0]        i_cfg_wr_data,
    input  var logic              push,
    output logic                  full,
    input  var lbs_pkg::t_in_item i_item,
    output logic                  empty,
    input  var logic              pop,
    output lbs_pkg::t_result      o_result
);

    logic          cmd_push;
    logic          cmd_full;
    logic          cmd_pop;
    logic          cmd_empty;
    lbs_pkg::t_cmd cmd_in;
    lbs_pkg::t_cmd cmd_head;

    lbs_front u_front (
        .i_item     (i_item),
        .i_push     (push),
        .o_full     (full),
        .o_cmd_push (cmd_push),
        .o_cmd      (cmd_in),
        .i_cmd_full (cmd_full)
    );

    lbs_cmd_queue u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (cmd_in),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_empty (cmd_empty),
        .o_head  (cmd_head)
    );

    lbs_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_cmd_empty   (cmd_empty),
        .i_cmd         (cmd_head),
        .o_cmd_pop     (cmd_pop),
        .o_empty       (empty),
        .i_pop         (pop),
        .o_result      (o_result)
    );

endmodule
`default_nettype wire
